/* sv/sng_pkg.sv */
`timescale 1ns / 1ps
package sng_pkg;

  // field widths
  localparam int SAMPLE_W   = 24;
  localparam int ENV_W      = 23;
  localparam int GAIN_W     = 17;
  localparam int COEF_W     = 16;
  localparam int RECIP_W    = 25;
  localparam int CFG_DATA_W = 25;
  localparam int CFG_IDX_W  = 3;

  // channel state sets
  localparam int NUM_CHANNELS = 2;
  localparam int CH_IDX_W     = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

  // shared multiplier, signed operands
  localparam int MUL_A_W = 34;
  localparam int MUL_B_W = 26;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;

  localparam logic [GAIN_W-1:0] ONE_Q16   = GAIN_W'(65536);
  localparam logic [ENV_W-1:0]  LEVEL_MAX = ENV_W'(8388607);

  // configuration reset values
  localparam logic [COEF_W-1:0]  RST_ENV_ATTACK   = COEF_W'(64068);
  localparam logic [COEF_W-1:0]  RST_ENV_RELEASE  = COEF_W'(65517);
  localparam logic [COEF_W-1:0]  RST_GAIN_ATTACK  = COEF_W'(62645);
  localparam logic [COEF_W-1:0]  RST_GAIN_RELEASE = COEF_W'(65511);
  localparam logic [ENV_W-1:0]   RST_KNEE_LOW     = ENV_W'(32768);
  localparam logic [ENV_W-1:0]   RST_KNEE_HIGH    = ENV_W'(55000);
  localparam logic [RECIP_W-1:0] RST_KNEE_RECIP   = RECIP_W'(2948000);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GATE_ENABLE   = 3'd0,
    REG_ENV_ATTACK    = 3'd1,
    REG_ENV_RELEASE   = 3'd2,
    REG_GAIN_ATTACK   = 3'd3,
    REG_GAIN_RELEASE  = 3'd4,
    REG_KNEE_LOW      = 3'd5,
    REG_KNEE_HIGH     = 3'd6,
    REG_KNEE_RECIP    = 3'd7
  } cfg_idx_t;

  typedef struct packed {
    logic                gate_enable;
    logic [COEF_W-1:0]   env_attack_coeff;
    logic [COEF_W-1:0]   env_release_coeff;
    logic [COEF_W-1:0]   gain_attack_coeff;
    logic [COEF_W-1:0]   gain_release_coeff;
    logic [ENV_W-1:0]    knee_low;
    logic [ENV_W-1:0]    knee_high;
    logic [RECIP_W-1:0]  knee_recip;
  } cfg_t;

  // controller states, one per datapath step
  typedef enum logic [4:0] {
    ST_IDLE,
    ST_LEVEL,
    ST_ENV_MUL0,
    ST_ENV_MUL1,
    ST_ENV_SUM,
    ST_KNEE_MUL,
    ST_KNEE_P,
    ST_P_SQUARE,
    ST_CUBE_MUL,
    ST_TARGET,
    ST_GAIN_MUL0,
    ST_GAIN_MUL1,
    ST_GAIN_SUM,
    ST_OUT_MUL,
    ST_RESULT,
    ST_BYPASS
  } state_t;

  // datapath operations
  typedef enum logic [4:0] {
    OP_NONE,
    OP_CAPTURE,
    OP_LEVEL,
    OP_ENV_MUL0,
    OP_ENV_MUL1,
    OP_ENV_SUM,
    OP_KNEE_MUL,
    OP_KNEE_P,
    OP_P_SQUARE,
    OP_CUBE_MUL,
    OP_TARGET,
    OP_GAIN_MUL0,
    OP_GAIN_MUL1,
    OP_GAIN_SUM,
    OP_OUT_MUL,
    OP_RESULT,
    OP_BYPASS
  } op_t;

  typedef struct packed {
    op_t  op;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic bypass;
  } status_t;

endpackage

/* sv/sng_if.sv */
`timescale 1ns / 1ps
// sample channel into the gate
interface sng_in_if;
  import sng_pkg::*;
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample_in;
  logic                       channel;

  modport source (output valid, output sample_in, output channel, input ready);
  modport sink (input valid, input sample_in, input channel, output ready);
endinterface

// gated result channel
interface sng_out_if;
  import sng_pkg::*;
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample_out;
  logic [GAIN_W-1:0]          gate_gain;
  logic                       out_channel;

  modport source (output valid, output sample_out, output gate_gain, output out_channel,
                  input ready);
  modport sink (input valid, input sample_out, input gate_gain, input out_channel,
                output ready);
endinterface

/* sv/sng_cfg.sv */
`timescale 1ns / 1ps
module sng_cfg (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              wr_en,
  input  logic [sng_pkg::CFG_IDX_W-1:0]     wr_index,
  input  logic [sng_pkg::CFG_DATA_W-1:0]    wr_data,
  output sng_pkg::cfg_t                     cfg
);
  import sng_pkg::*;

  // register file with write decode
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.gate_enable        <= 1'b1;
      cfg.env_attack_coeff   <= RST_ENV_ATTACK;
      cfg.env_release_coeff  <= RST_ENV_RELEASE;
      cfg.gain_attack_coeff  <= RST_GAIN_ATTACK;
      cfg.gain_release_coeff <= RST_GAIN_RELEASE;
      cfg.knee_low           <= RST_KNEE_LOW;
      cfg.knee_high          <= RST_KNEE_HIGH;
      cfg.knee_recip         <= RST_KNEE_RECIP;
    end else if (wr_en) begin
      unique case (cfg_idx_t'(wr_index))
        REG_GATE_ENABLE:  cfg.gate_enable        <= wr_data[0];
        REG_ENV_ATTACK:   cfg.env_attack_coeff   <= wr_data[COEF_W-1:0];
        REG_ENV_RELEASE:  cfg.env_release_coeff  <= wr_data[COEF_W-1:0];
        REG_GAIN_ATTACK:  cfg.gain_attack_coeff  <= wr_data[COEF_W-1:0];
        REG_GAIN_RELEASE: cfg.gain_release_coeff <= wr_data[COEF_W-1:0];
        REG_KNEE_LOW:     cfg.knee_low           <= wr_data[ENV_W-1:0];
        REG_KNEE_HIGH:    cfg.knee_high          <= wr_data[ENV_W-1:0];
        REG_KNEE_RECIP:   cfg.knee_recip         <= wr_data[RECIP_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

/* sv/sng_ctrl.sv */
`timescale 1ns / 1ps
module sng_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              out_ready,
  output logic              out_valid,
  input  sng_pkg::status_t  status,
  output sng_pkg::cmd_t     cmd
);
  import sng_pkg::*;

  state_t state, state_next;
  logic   out_busy;

  assign out_busy = out_valid && !out_ready;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:      if (in_valid) state_next = ST_LEVEL;
      ST_LEVEL:     state_next = status.bypass ? ST_BYPASS : ST_ENV_MUL0;
      ST_ENV_MUL0:  state_next = ST_ENV_MUL1;
      ST_ENV_MUL1:  state_next = ST_ENV_SUM;
      ST_ENV_SUM:   state_next = ST_KNEE_MUL;
      ST_KNEE_MUL:  state_next = ST_KNEE_P;
      ST_KNEE_P:    state_next = ST_P_SQUARE;
      ST_P_SQUARE:  state_next = ST_CUBE_MUL;
      ST_CUBE_MUL:  state_next = ST_TARGET;
      ST_TARGET:    state_next = ST_GAIN_MUL0;
      ST_GAIN_MUL0: state_next = ST_GAIN_MUL1;
      ST_GAIN_MUL1: state_next = ST_GAIN_SUM;
      ST_GAIN_SUM:  state_next = ST_OUT_MUL;
      ST_OUT_MUL:   state_next = ST_RESULT;
      ST_RESULT:    if (!out_busy) state_next = ST_IDLE;
      ST_BYPASS:    if (!out_busy) state_next = ST_IDLE;
      default:      state_next = ST_IDLE;
    endcase
  end

  // outputs: datapath command and input ready
  always_comb begin
    cmd.op       = OP_NONE;
    cmd.out_load = 1'b0;
    in_ready     = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) cmd.op = OP_CAPTURE;
      end
      ST_LEVEL:     cmd.op = OP_LEVEL;
      ST_ENV_MUL0:  cmd.op = OP_ENV_MUL0;
      ST_ENV_MUL1:  cmd.op = OP_ENV_MUL1;
      ST_ENV_SUM:   cmd.op = OP_ENV_SUM;
      ST_KNEE_MUL:  cmd.op = OP_KNEE_MUL;
      ST_KNEE_P:    cmd.op = OP_KNEE_P;
      ST_P_SQUARE:  cmd.op = OP_P_SQUARE;
      ST_CUBE_MUL:  cmd.op = OP_CUBE_MUL;
      ST_TARGET:    cmd.op = OP_TARGET;
      ST_GAIN_MUL0: cmd.op = OP_GAIN_MUL0;
      ST_GAIN_MUL1: cmd.op = OP_GAIN_MUL1;
      ST_GAIN_SUM:  cmd.op = OP_GAIN_SUM;
      ST_OUT_MUL:   cmd.op = OP_OUT_MUL;
      ST_RESULT: begin
        cmd.op       = OP_RESULT;
        cmd.out_load = !out_busy;
      end
      ST_BYPASS: begin
        cmd.op       = OP_BYPASS;
        cmd.out_load = !out_busy;
      end
      default: ;
    endcase
  end

  // output valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

endmodule

/* sv/sng_dp.sv */
`timescale 1ns / 1ps
module sng_dp (
  input  logic                              clk,
  input  logic                              rst,
  input  sng_pkg::cfg_t                     cfg,
  input  sng_pkg::cmd_t                     cmd,
  output sng_pkg::status_t                  status,
  input  logic signed [sng_pkg::SAMPLE_W-1:0] sample_in,
  input  logic                              channel,
  output logic signed [sng_pkg::SAMPLE_W-1:0] sample_out,
  output logic [sng_pkg::GAIN_W-1:0]        gate_gain,
  output logic                              out_channel
);
  import sng_pkg::*;

  localparam logic signed [PROD_W-1:0] RES_MAX = PROD_W'(2 ** (SAMPLE_W - 1) - 1);
  localparam logic signed [PROD_W-1:0] RES_MIN = -RES_MAX - PROD_W'(1);
  localparam logic [PROD_W-1:0]        HALF_16 = PROD_W'(32768);
  localparam logic [PROD_W-1:0]        HALF_20 = PROD_W'(2 ** 19);
  localparam logic [PROD_W-1:0]        HALF_32 = PROD_W'(64'h8000_0000);

  // per-channel state
  logic [ENV_W-1:0]  env_mem  [NUM_CHANNELS];
  logic [GAIN_W-1:0] gain_mem [NUM_CHANNELS];

  // working registers
  logic signed [SAMPLE_W-1:0] s_reg;
  logic                       ch_reg;
  logic [CH_IDX_W-1:0]        idx;
  logic [ENV_W-1:0]           level;
  logic [ENV_W-1:0]           env_old;
  logic [ENV_W-1:0]           env_new;
  logic [GAIN_W-1:0]          g_old;
  logic [GAIN_W-1:0]          g_new;
  logic [COEF_W-1:0]          coef;
  logic [GAIN_W-1:0]          p_reg;
  logic [GAIN_W-1:0]          target;
  logic signed [PROD_W-1:0]   acc;
  logic signed [PROD_W-1:0]   prod;

  // combinational helpers
  logic signed [MUL_A_W-1:0]  mul_a;
  logic signed [MUL_B_W-1:0]  mul_b;
  logic                       mul_en;
  logic [SAMPLE_W-1:0]        mag;
  logic [ENV_W-1:0]           level_sat;
  logic [COEF_W-1:0]          env_coef;
  logic [COEF_W-1:0]          gain_coef;
  logic [GAIN_W-1:0]          coef_rest;
  logic [PROD_W-1:0]          blend_sum;
  logic [PROD_W-1:0]          blend_q;
  logic [PROD_W-1:0]          p_q;
  logic [PROD_W-1:0]          t_q;
  logic [GAIN_W-1:0]          t_curve;
  logic [GAIN_W+1:0]          cube_fac;
  logic signed [PROD_W-1:0]   res_q;
  logic signed [PROD_W-1:0]   res_sat;

  assign status.bypass = !cfg.gate_enable;

  // absolute level with saturation of the most negative code
  assign mag       = s_reg[SAMPLE_W-1] ? (~s_reg + SAMPLE_W'(1)) : s_reg;
  assign level_sat = mag[SAMPLE_W-1] ? LEVEL_MAX : mag[ENV_W-1:0];

  // attack or release selection
  assign env_coef  = (level > env_old) ? cfg.env_attack_coeff : cfg.env_release_coeff;
  assign gain_coef = (target > g_old) ? cfg.gain_attack_coeff : cfg.gain_release_coeff;
  assign coef_rest = ONE_Q16 - GAIN_W'(coef);

  // rounded blend of two products, and knee terms
  assign blend_sum = PROD_W'(acc) + PROD_W'(prod) + HALF_16;
  assign blend_q   = blend_sum >> 16;
  assign p_q       = (PROD_W'(prod) + HALF_20) >> 20;
  assign t_q       = (PROD_W'(prod) + HALF_32) >> 32;
  assign t_curve   = (t_q > PROD_W'(ONE_Q16)) ? ONE_Q16 : t_q[GAIN_W-1:0];
  assign cube_fac  = (GAIN_W+2)'(196608) - {1'b0, p_reg, 1'b0};
  assign res_q     = (prod + PROD_W'(32768)) >>> 16;
  assign res_sat   = (res_q > RES_MAX) ? RES_MAX : ((res_q < RES_MIN) ? RES_MIN : res_q);

  // shared multiplier operand select
  always_comb begin
    mul_a  = '0;
    mul_b  = '0;
    mul_en = 1'b1;
    case (cmd.op)
      OP_ENV_MUL0: begin
        mul_a = MUL_A_W'(env_coef);
        mul_b = MUL_B_W'(env_old);
      end
      OP_ENV_MUL1: begin
        mul_a = MUL_A_W'(coef_rest);
        mul_b = MUL_B_W'(level);
      end
      OP_KNEE_MUL: begin
        mul_a = MUL_A_W'(ENV_W'(env_new - cfg.knee_low));
        mul_b = MUL_B_W'(cfg.knee_recip);
      end
      OP_P_SQUARE: begin
        mul_a = MUL_A_W'(p_reg);
        mul_b = MUL_B_W'(p_reg);
      end
      OP_CUBE_MUL: begin
        mul_a = prod[MUL_A_W-1:0];
        mul_b = MUL_B_W'(cube_fac);
      end
      OP_GAIN_MUL0: begin
        mul_a = MUL_A_W'(gain_coef);
        mul_b = MUL_B_W'(g_old);
      end
      OP_GAIN_MUL1: begin
        mul_a = MUL_A_W'(coef_rest);
        mul_b = MUL_B_W'(target);
      end
      OP_OUT_MUL: begin
        mul_a = MUL_A_W'(s_reg);
        mul_b = MUL_B_W'(g_new);
      end
      default: mul_en = 1'b0;
    endcase
  end

  // product register
  always_ff @(posedge clk) begin
    if (mul_en) begin
      prod <= mul_a * mul_b;
    end
  end

  // working registers per step
  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_CAPTURE: begin
        s_reg  <= sample_in;
        ch_reg <= channel;
        idx    <= CH_IDX_W'(int'(channel) % NUM_CHANNELS);
      end
      OP_LEVEL: begin
        level   <= level_sat;
        env_old <= env_mem[idx];
        g_old   <= gain_mem[idx];
      end
      OP_ENV_MUL0:  coef <= env_coef;
      OP_ENV_MUL1:  acc  <= prod;
      OP_ENV_SUM:   env_new <= (blend_q > PROD_W'(LEVEL_MAX)) ? LEVEL_MAX : blend_q[ENV_W-1:0];
      OP_KNEE_P:    p_reg <= (p_q > PROD_W'(ONE_Q16)) ? ONE_Q16 : p_q[GAIN_W-1:0];
      OP_TARGET: begin
        if (env_new <= cfg.knee_low) begin
          target <= '0;
        end else if (env_new >= cfg.knee_high) begin
          target <= ONE_Q16;
        end else begin
          target <= t_curve;
        end
      end
      OP_GAIN_MUL0: coef <= gain_coef;
      OP_GAIN_MUL1: acc  <= prod;
      OP_GAIN_SUM:  g_new <= (blend_q > PROD_W'(ONE_Q16)) ? ONE_Q16 : blend_q[GAIN_W-1:0];
      default: ;
    endcase
  end

  // channel state update
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        env_mem[i]  <= '0;
        gain_mem[i] <= ONE_Q16;
      end
    end else begin
      case (cmd.op)
        OP_ENV_SUM: begin
          env_mem[idx] <= (blend_q > PROD_W'(LEVEL_MAX)) ? LEVEL_MAX : blend_q[ENV_W-1:0];
        end
        OP_GAIN_SUM: begin
          gain_mem[idx] <= (blend_q > PROD_W'(ONE_Q16)) ? ONE_Q16 : blend_q[GAIN_W-1:0];
        end
        OP_BYPASS: begin
          env_mem[idx]  <= level;
          gain_mem[idx] <= ONE_Q16;
        end
        default: ;
      endcase
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_channel <= ch_reg;
      if (cmd.op == OP_BYPASS) begin
        sample_out <= s_reg;
        gate_gain  <= ONE_Q16;
      end else begin
        sample_out <= res_sat[SAMPLE_W-1:0];
        gate_gain  <= g_new;
      end
    end
  end

endmodule

/* sv/smooth_noise_gate_unit.sv */
`timescale 1ns / 1ps
// samples pass the controller steps from level to result (level and bypass with the gate disabled)
// one sample is in work at a time, taken only in idle; the controller walks the single shared
//   34x26 multiplier through eight products per sample
// reset: configuration to defaults, envelopes to zero, gains to unity, output empty
module smooth_noise_gate_unit (
  input  logic                              clk,
  input  logic                              rst,
  sng_in_if.sink                            audio,
  sng_out_if.source                         gated,
  input  logic                              wr_en,
  input  logic [sng_pkg::CFG_IDX_W-1:0]     wr_index,
  input  logic [sng_pkg::CFG_DATA_W-1:0]    wr_data
);
  import sng_pkg::*;

  cfg_t    cfg;
  cmd_t    cmd;
  status_t status;

  // configuration registers
  sng_cfg u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data),
    .cfg      (cfg)
  );

  // sequencer
  sng_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (audio.valid),
    .in_ready  (audio.ready),
    .out_ready (gated.ready),
    .out_valid (gated.valid),
    .status    (status),
    .cmd       (cmd)
  );

  // arithmetic and channel state
  sng_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .cmd         (cmd),
    .status      (status),
    .sample_in   (audio.sample_in),
    .channel     (audio.channel),
    .sample_out  (gated.sample_out),
    .gate_gain   (gated.gate_gain),
    .out_channel (gated.out_channel)
  );

endmodule

/* sv/sng_checker.sv */
`timescale 1ns / 1ps
module sng_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              in_valid,
  input logic                              in_ready,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic [sng_pkg::SAMPLE_W-1:0]      sample_out,
  input logic [sng_pkg::GAIN_W-1:0]        gate_gain,
  input logic                              out_channel
);
  import sng_pkg::*;

  // output is empty right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  // one sample in work at a time
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input taken again while a sample is in work");

  // gain never above unity
  a_gain_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (gate_gain <= ONE_Q16))
    else $error("gate gain above unity");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(sample_out) &&
      $stable(gate_gain) && $stable(out_channel)))
    else $error("stalled result changed");

endmodule

bind smooth_noise_gate_unit sng_checker u_sng_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (audio.valid),
  .in_ready    (audio.ready),
  .out_valid   (gated.valid),
  .out_ready   (gated.ready),
  .sample_out  (gated.sample_out),
  .gate_gain   (gated.gate_gain),
  .out_channel (gated.out_channel)
);
